@@ sv/ice_pkg.sv @@
// Shared types and constants for the input event coalescer.
`timescale 1ns / 1ps

package ice_pkg;

  // Number of axes in a controller event: two triggers, four stick axes.
  localparam int PAD_AXES = 6;
  localparam int AXIS_COUNT_DEF = 6;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_UP   = 2'd1,
    TREND_DOWN = 2'd2
  } trend_t;

  // One input item as it sits in the input register.
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        pad;
    logic [15:0]       btn;
    logic [1:0][7:0]   trig;   // [0] left, [1] right
    logic [3:0][15:0]  stick;  // left x, left y, right x, right y
    logic [1:0][15:0]  move;   // x, y
  } item_t;

  // One result item.
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        pad;
    logic [15:0]       btn;
    logic [1:0][7:0]   trig;
    logic [3:0][15:0]  stick;
    logic [1:0][15:0]  move;
    logic              last;
  } result_t;

  // Merge unit status toward the top level.
  typedef struct packed {
    logic       held_valid;
    logic [1:0] res_count;
  } merge_stat_t;

  // Result buffer status toward the top level.
  typedef struct packed {
    logic ready;
    logic head_v;
    logic tail_v;
  } obuf_stat_t;

endpackage

@@ sv/ice_merge.sv @@
// Pending event store and merge decision for the input event coalescer.
`timescale 1ns / 1ps

module ice_merge #(
  parameter int AXIS_COUNT = ice_pkg::AXIS_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ice_pkg::item_t      item,
  output ice_pkg::result_t    res0,
  output ice_pkg::result_t    res1,
  output ice_pkg::merge_stat_t stat
);
  import ice_pkg::*;

  localparam int TRACKED = (AXIS_COUNT < PAD_AXES) ? AXIS_COUNT : PAD_AXES;

  logic                held_valid_r, held_valid_nxt;
  logic                held_is_pad_r, held_is_pad_nxt;
  logic [3:0]          held_pad_r, held_pad_nxt;
  logic [15:0]         held_btn_r, held_btn_nxt;
  logic [1:0][7:0]     held_trig_r, held_trig_nxt;
  logic [3:0][15:0]    held_stick_r, held_stick_nxt;
  logic [1:0][15:0]    held_move_r, held_move_nxt;
  trend_t              trend_r   [TRACKED];
  trend_t              trend_nxt [TRACKED];
  trend_t              trend_upd [TRACKED];

  logic signed [16:0]  cur_ax [PAD_AXES];
  logic signed [16:0]  new_ax [PAD_AXES];
  logic [PAD_AXES-1:0] ax_ok;

  logic signed [16:0]  sum_x, sum_y;
  logic                mv_ok, pad_ok;
  result_t             emit, marker;

  // Axis values widened to 17 bits: triggers unsigned, sticks signed.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cur_ax[i] = $signed({9'd0, held_trig_r[i]});
      new_ax[i] = $signed({9'd0, item.trig[i]});
    end
    for (int i = 0; i < 4; i++) begin
      cur_ax[i+2] = $signed({held_stick_r[i][15], held_stick_r[i]});
      new_ax[i+2] = $signed({item.stick[i][15], item.stick[i]});
    end
  end

  for (genvar a = 0; a < PAD_AXES; a++) begin : g_axis
    if (a < TRACKED) begin : g_trk
      always_comb begin
        trend_upd[a] = trend_r[a];
        if (cur_ax[a] == new_ax[a]) begin
          ax_ok[a] = 1'b1;
        end else if (new_ax[a] == 17'sd0) begin
          ax_ok[a] = 1'b0;
        end else begin
          case (trend_r[a])
            TREND_NONE: begin
              ax_ok[a]     = 1'b1;
              trend_upd[a] = (new_ax[a] < cur_ax[a]) ? TREND_DOWN : TREND_UP;
            end
            TREND_DOWN: ax_ok[a] = new_ax[a] < cur_ax[a];
            default:    ax_ok[a] = new_ax[a] > cur_ax[a];
          endcase
        end
      end
    end else begin : g_fix
      // Untracked axis must hold still.
      assign ax_ok[a] = (cur_ax[a] == new_ax[a]);
    end
  end

  assign sum_x = $signed({held_move_r[0][15], held_move_r[0]})
               + $signed({item.move[0][15], item.move[0]});
  assign sum_y = $signed({held_move_r[1][15], held_move_r[1]})
               + $signed({item.move[1][15], item.move[1]});

  assign mv_ok  = held_valid_r && !held_is_pad_r
               && (sum_x[16] == sum_x[15]) && (sum_y[16] == sum_y[15]);
  assign pad_ok = held_valid_r && held_is_pad_r && (held_pad_r == item.pad)
               && (held_btn_r == item.btn) && (&ax_ok);

  // Results: pending event first, marker second.
  always_comb begin
    emit       = '0;
    emit.kind  = held_is_pad_r ? KIND_PAD : KIND_MOVE;
    emit.pad   = held_pad_r;
    emit.btn   = held_btn_r;
    emit.trig  = held_trig_r;
    emit.stick = held_stick_r;
    emit.move  = held_move_r;

    marker      = '0;
    marker.kind = KIND_OTHER;
    marker.last = 1'b1;

    res0      = held_valid_r ? emit : marker;
    res0.last = !((item.kind == KIND_OTHER) && held_valid_r);
    res1      = marker;

    case (item.kind)
      KIND_MOVE:  stat.res_count = (held_valid_r && !mv_ok)  ? 2'd1 : 2'd0;
      KIND_PAD:   stat.res_count = (held_valid_r && !pad_ok) ? 2'd1 : 2'd0;
      KIND_OTHER: stat.res_count = held_valid_r ? 2'd2 : 2'd1;
      default:    stat.res_count = held_valid_r ? 2'd1 : 2'd0;
    endcase
    stat.held_valid = held_valid_r;
  end

  always_comb begin
    held_valid_nxt  = held_valid_r;
    held_is_pad_nxt = held_is_pad_r;
    held_pad_nxt    = held_pad_r;
    held_btn_nxt    = held_btn_r;
    held_trig_nxt   = held_trig_r;
    held_stick_nxt  = held_stick_r;
    held_move_nxt   = held_move_r;
    for (int i = 0; i < TRACKED; i++) trend_nxt[i] = trend_r[i];

    if (fire) begin
      case (item.kind)
        KIND_MOVE: begin
          if (mv_ok) begin
            held_move_nxt[0] = sum_x[15:0];
            held_move_nxt[1] = sum_y[15:0];
          end else begin
            held_valid_nxt  = 1'b1;
            held_is_pad_nxt = 1'b0;
            held_pad_nxt    = '0;
            held_btn_nxt    = '0;
            held_trig_nxt   = '0;
            held_stick_nxt  = '0;
            held_move_nxt   = item.move;
            for (int i = 0; i < TRACKED; i++) trend_nxt[i] = TREND_NONE;
          end
        end
        KIND_PAD: begin
          if (pad_ok) begin
            held_trig_nxt  = item.trig;
            held_stick_nxt = item.stick;
            for (int i = 0; i < TRACKED; i++) trend_nxt[i] = trend_upd[i];
          end else begin
            held_valid_nxt  = 1'b1;
            held_is_pad_nxt = 1'b1;
            held_pad_nxt    = item.pad;
            held_btn_nxt    = item.btn;
            held_trig_nxt   = item.trig;
            held_stick_nxt  = item.stick;
            held_move_nxt   = '0;
            for (int i = 0; i < TRACKED; i++) trend_nxt[i] = TREND_NONE;
          end
        end
        default: begin
          held_valid_nxt  = 1'b0;
          held_is_pad_nxt = 1'b0;
          held_pad_nxt    = '0;
          held_btn_nxt    = '0;
          held_trig_nxt   = '0;
          held_stick_nxt  = '0;
          held_move_nxt   = '0;
          for (int i = 0; i < TRACKED; i++) trend_nxt[i] = TREND_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_is_pad_r <= 1'b0;
      held_pad_r    <= '0;
      held_btn_r    <= '0;
      held_trig_r   <= '0;
      held_stick_r  <= '0;
      held_move_r   <= '0;
      for (int i = 0; i < TRACKED; i++) trend_r[i] <= TREND_NONE;
    end else begin
      held_valid_r  <= held_valid_nxt;
      held_is_pad_r <= held_is_pad_nxt;
      held_pad_r    <= held_pad_nxt;
      held_btn_r    <= held_btn_nxt;
      held_trig_r   <= held_trig_nxt;
      held_stick_r  <= held_stick_nxt;
      held_move_r   <= held_move_nxt;
      for (int i = 0; i < TRACKED; i++) trend_r[i] <= trend_nxt[i];
    end
  end

endmodule

@@ sv/ice_obuf.sv @@
// Two-entry result buffer that drives the result channel.
`timescale 1ns / 1ps

module ice_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_count,
  input  ice_pkg::result_t    res0,
  input  ice_pkg::result_t    res1,
  input  logic                out_stall,
  output logic                out_valid,
  output ice_pkg::result_t    head,
  output ice_pkg::obuf_stat_t stat
);
  import ice_pkg::*;

  logic    head_v_r, head_v_nxt;
  logic    tail_v_r, tail_v_nxt;
  result_t head_r, head_nxt;
  result_t tail_r, tail_nxt;
  logic    pop;

  assign pop = head_v_r && !out_stall;

  // Take new results only when the buffer is empty or drains empty this cycle.
  assign stat.ready  = !head_v_r || (!tail_v_r && pop);
  assign stat.head_v = head_v_r;
  assign stat.tail_v = tail_v_r;

  always_comb begin
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    if (pop) begin
      head_v_nxt = tail_v_r;
      head_nxt   = tail_r;
      tail_v_nxt = 1'b0;
    end
    if (push_count != 2'd0) begin
      head_v_nxt = 1'b1;
      head_nxt   = res0;
      tail_v_nxt = (push_count == 2'd2);
      tail_nxt   = res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_valid = head_v_r;
  assign head      = head_r;

endmodule

@@ sv/input_event_coalescer_core.sv @@
// Top level of the input event coalescer: input register, merge unit, result buffer.
`timescale 1ns / 1ps

//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | in_event_kind, pad, buttons, triggers,
//           |                      | sticks, mouse deltas
//  result   | out_valid / out_stall| out_kind, pad, buttons, triggers, sticks,
//           |                      | mouse deltas, out_last_of_run
//
//  An item moves from the input register through the merge unit into the
//  result buffer, whose registered head drives the result ports. Items
//  that merge or give one result go at one per cycle while out_stall is
//  low; an item that gives two results (other event behind a pending one)
//  fills the two-entry result buffer, and the next item waits until the
//  single result port drains it. Reset is synchronous, active low, and
//  leaves nothing pending. While a result waits in the buffer the input
//  register takes one more item, then stalls input until the buffer drains.

module input_event_coalescer_core #(
  parameter int AXIS_COUNT = ice_pkg::AXIS_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_event_kind,
  input  logic [3:0]         in_pad_number,
  input  logic [15:0]        in_button_mask,
  input  logic [7:0]         in_trigger_left,
  input  logic [7:0]         in_trigger_right,
  input  logic signed [15:0] in_stick_left_x,
  input  logic signed [15:0] in_stick_left_y,
  input  logic signed [15:0] in_stick_right_x,
  input  logic signed [15:0] in_stick_right_y,
  input  logic signed [15:0] in_move_x,
  input  logic signed [15:0] in_move_y,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [3:0]         out_pad_number,
  output logic [15:0]        out_button_mask,
  output logic [7:0]         out_trigger_left,
  output logic [7:0]         out_trigger_right,
  output logic signed [15:0] out_stick_left_x,
  output logic signed [15:0] out_stick_left_y,
  output logic signed [15:0] out_stick_right_x,
  output logic signed [15:0] out_stick_right_y,
  output logic signed [15:0] out_move_x,
  output logic signed [15:0] out_move_y,
  output logic               out_last_of_run
);
  import ice_pkg::*;

  logic        in_v_r, in_v_nxt;
  item_t       item_r, item_nxt;
  item_t       in_item;
  logic        fire;
  logic [1:0]  push_count;
  result_t     res0, res1, head;
  merge_stat_t mstat;
  obuf_stat_t  ostat;

  // Gather the input ports into one item.
  always_comb begin
    in_item.kind     = kind_t'(in_event_kind);
    in_item.pad      = in_pad_number;
    in_item.btn      = in_button_mask;
    in_item.trig[0]  = in_trigger_left;
    in_item.trig[1]  = in_trigger_right;
    in_item.stick[0] = in_stick_left_x;
    in_item.stick[1] = in_stick_left_y;
    in_item.stick[2] = in_stick_right_x;
    in_item.stick[3] = in_stick_right_y;
    in_item.move[0]  = in_move_x;
    in_item.move[1]  = in_move_y;
  end

  // Process the registered item once the result buffer can take both results.
  assign fire     = in_v_r && ostat.ready;
  assign in_stall = in_v_r && !fire;

  // Refill the input register whenever it empties or advances this cycle.
  always_comb begin
    in_v_nxt = in_v_r;
    item_nxt = item_r;
    if (!in_stall) begin
      in_v_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    item_r <= item_nxt;
  end

  ice_merge #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res0  (res0),
    .res1  (res1),
    .stat  (mstat)
  );

  // Drop the result count when the item is not taken this cycle.
  assign push_count = fire ? mstat.res_count : 2'd0;

  ice_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (push_count),
    .res0       (res0),
    .res1       (res1),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .head       (head),
    .stat       (ostat)
  );

  // Drive the result ports from the buffer head.
  assign out_kind          = head.kind;
  assign out_pad_number    = head.pad;
  assign out_button_mask   = head.btn;
  assign out_trigger_left  = head.trig[0];
  assign out_trigger_right = head.trig[1];
  assign out_stick_left_x  = head.stick[0];
  assign out_stick_left_y  = head.stick[1];
  assign out_stick_right_x = head.stick[2];
  assign out_stick_right_y = head.stick[3];
  assign out_move_x        = head.move[0];
  assign out_move_y        = head.move[1];
  assign out_last_of_run   = head.last;

  // Other events and flushes leave nothing pending.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item_r.kind == KIND_OTHER || item_r.kind == KIND_FLUSH)
      |=> !mstat.held_valid)
    else $error("pending event survived a flush");

  // An other event always shows a result in the next cycle.
  a_other_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_r.kind == KIND_OTHER |=> out_valid)
    else $error("other event gave no result");

  // The second buffer entry is only ever used behind the first.
  a_tail_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    ostat.tail_v |-> ostat.head_v)
    else $error("result buffer tail valid without head");

  // A result that does not end its run always has its follower buffered.
  a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> ostat.tail_v)
    else $error("non-final result without follower");

endmodule
